// ===== rtl/sprm_pkg.sv =====
// sprm_pkg: widths, constants and controller interface types of the stereo level meter
// used by every module of the block; depends on nothing

package sprm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_FRAMES  = 4096;

    localparam int MAG_W   = SAMPLE_BITS;          // magnitude 0 .. 2^23
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;  // square at most 2^46
    localparam int CNT_W   = 13;                   // frame count 0 .. 4096
    localparam int SUM_W   = SQ_W + CNT_W - 1;     // 4096 squares of 2^46 fit
    localparam int REM_W   = CNT_W;                // divider remainder
    localparam int RAD_W   = SQ_W + 1;             // radicand padded to whole bit pairs
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SREM_W  = ROOT_W + 1;           // square root remainder
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W  = 6;

    localparam int S_DATA_W = 48;   // two samples, whole bytes
    localparam int M_DATA_W = 112;  // four levels and a count, whole bytes

    // controller to datapath
    typedef struct packed {
        logic div_load;    // load dividend and divisor, clear the root
        logic div_step;    // one quotient bit
        logic sqrt_step;   // one root bit
        logic store_rms;   // keep the root for the current channel
        logic emit;        // load the output register
        logic chan;        // 0 left, 1 right
    } sprm_cmd_t;

    // datapath and ports to controller
    typedef struct packed {
        logic in_last;     // the word offered closes a block
        logic snap_done;   // block totals captured
        logic out_free;    // output register can take a word
    } sprm_stat_t;

endpackage

// ===== rtl/sprm_accum.sv =====
// sprm_accum: per-frame pipeline with magnitude, square, peak and square-sum accumulation
// keeps a snapshot of the totals of the last finished block; depends on sprm_pkg

module sprm_accum (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   accept,
    input  logic                                   mono_mode,
    input  logic signed [sprm_pkg::SAMPLE_BITS-1:0] sample_left,
    input  logic signed [sprm_pkg::SAMPLE_BITS-1:0] sample_right,
    input  logic                                   block_end,
    output logic                                   snap_done,
    output logic [sprm_pkg::MAG_W-1:0]             peak_left,
    output logic [sprm_pkg::MAG_W-1:0]             peak_right,
    output logic [sprm_pkg::SUM_W-1:0]             sum_left,
    output logic [sprm_pkg::SUM_W-1:0]             sum_right,
    output logic [sprm_pkg::CNT_W-1:0]             frames
);
    import sprm_pkg::*;

    logic             vld_a_reg, last_a_reg;
    logic [MAG_W-1:0] mag_l_a_reg, mag_r_a_reg;
    logic             vld_b_reg, last_b_reg;
    logic [MAG_W-1:0] mag_l_b_reg, mag_r_b_reg;
    logic [SQ_W-1:0]  sq_l_b_reg, sq_r_b_reg;

    logic [MAG_W-1:0] pk_l_reg, pk_r_reg, pk_l_next, pk_r_next;
    logic [SUM_W-1:0] sum_l_reg, sum_r_reg, sum_l_next, sum_r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [MAG_W-1:0] snap_pk_l_reg, snap_pk_r_reg;
    logic [SUM_W-1:0] snap_sum_l_reg, snap_sum_r_reg;
    logic [CNT_W-1:0] snap_cnt_reg;
    logic             snap_done_reg;

    logic [MAG_W-1:0] mag_l, mag_r;
    logic [2*MAG_W-1:0] prod_l, prod_r;

    // two's complement magnitude; the most negative code maps to 2^23
    assign mag_l = sample_left[SAMPLE_BITS-1]  ? MAG_W'(~sample_left + 1'b1)  : MAG_W'(sample_left);
    assign mag_r = mono_mode ? mag_l :
                   (sample_right[SAMPLE_BITS-1] ? MAG_W'(~sample_right + 1'b1)
                                                : MAG_W'(sample_right));

    assign prod_l = mag_l_a_reg * mag_l_a_reg;
    assign prod_r = mag_r_a_reg * mag_r_a_reg;

    always_comb begin
        pk_l_next  = (mag_l_b_reg > pk_l_reg) ? mag_l_b_reg : pk_l_reg;
        pk_r_next  = (mag_r_b_reg > pk_r_reg) ? mag_r_b_reg : pk_r_reg;
        sum_l_next = sum_l_reg;
        sum_r_next = sum_r_reg;
        cnt_next   = cnt_reg;
        // past the maximum block length only the peaks move
        if (cnt_reg < CNT_W'(MAX_FRAMES)) begin
            sum_l_next = sum_l_reg + SUM_W'(sq_l_b_reg);
            sum_r_next = sum_r_reg + SUM_W'(sq_r_b_reg);
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            pk_l_reg      <= '0;
            pk_r_reg      <= '0;
            sum_l_reg     <= '0;
            sum_r_reg     <= '0;
            cnt_reg       <= '0;
            snap_done_reg <= 1'b0;
        end else begin
            vld_a_reg     <= accept;
            vld_b_reg     <= vld_a_reg;
            snap_done_reg <= vld_b_reg && last_b_reg;
            if (vld_b_reg) begin
                if (last_b_reg) begin
                    pk_l_reg  <= '0;
                    pk_r_reg  <= '0;
                    sum_l_reg <= '0;
                    sum_r_reg <= '0;
                    cnt_reg   <= '0;
                end else begin
                    pk_l_reg  <= pk_l_next;
                    pk_r_reg  <= pk_r_next;
                    sum_l_reg <= sum_l_next;
                    sum_r_reg <= sum_r_next;
                    cnt_reg   <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_l_a_reg <= mag_l;
            mag_r_a_reg <= mag_r;
            last_a_reg  <= block_end;
        end
        mag_l_b_reg <= mag_l_a_reg;
        mag_r_b_reg <= mag_r_a_reg;
        sq_l_b_reg  <= prod_l[SQ_W-1:0];
        sq_r_b_reg  <= prod_r[SQ_W-1:0];
        last_b_reg  <= last_a_reg;
        if (vld_b_reg && last_b_reg) begin
            snap_pk_l_reg  <= pk_l_next;
            snap_pk_r_reg  <= pk_r_next;
            snap_sum_l_reg <= sum_l_next;
            snap_sum_r_reg <= sum_r_next;
            snap_cnt_reg   <= cnt_next;
        end
    end

    assign snap_done  = snap_done_reg;
    assign peak_left  = snap_pk_l_reg;
    assign peak_right = snap_pk_r_reg;
    assign sum_left   = snap_sum_l_reg;
    assign sum_right  = snap_sum_r_reg;
    assign frames     = snap_cnt_reg;

endmodule

// ===== rtl/sprm_arith.sv =====
// sprm_arith: bit-serial divider and digit-by-digit square root shared by both channels
// computes floor(sqrt(floor(sum / count))) under controller commands; depends on sprm_pkg

module sprm_arith (
    input  logic                          aclk,
    input  sprm_pkg::sprm_cmd_t           cmd,
    input  logic [sprm_pkg::SUM_W-1:0]    sum_left,
    input  logic [sprm_pkg::SUM_W-1:0]    sum_right,
    input  logic [sprm_pkg::CNT_W-1:0]    frames,
    output logic [sprm_pkg::ROOT_W-1:0]   rms_left,
    output logic [sprm_pkg::ROOT_W-1:0]   rms_right
);
    import sprm_pkg::*;

    logic [SUM_W-1:0]  quo_reg;     // dividend in, quotient out, then radicand
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SREM_W-1:0] srem_reg;
    logic              chan_reg;    // channel of the root in progress
    logic [ROOT_W-1:0] rms_l_reg, rms_r_reg;

    logic [REM_W:0]    rem_sh;
    logic              rem_ge;
    logic [REM_W:0]    rem_diff;
    logic [SREM_W+1:0] s_acc, s_trial, s_diff;
    logic              s_ge;

    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    // radicand bit pairs come from the top of the padded quotient
    assign s_acc   = {srem_reg, quo_reg[RAD_W-1:RAD_W-2]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_ge    = s_acc >= s_trial;
    assign s_diff  = s_acc - s_trial;

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg  <= cmd.chan ? sum_right : sum_left;
            den_reg  <= frames;
            rem_reg  <= '0;
            root_reg <= '0;
            srem_reg <= '0;
            chan_reg <= cmd.chan;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
        end else if (cmd.sqrt_step) begin
            srem_reg <= s_ge ? s_diff[SREM_W-1:0] : s_acc[SREM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], s_ge};
            quo_reg  <= {quo_reg[SUM_W-3:0], 2'b00};
        end
        // the store may share its cycle with the load of the next channel
        if (cmd.store_rms) begin
            if (chan_reg) begin
                rms_r_reg <= root_reg;
            end else begin
                rms_l_reg <= root_reg;
            end
        end
    end

    assign rms_left  = rms_l_reg;
    assign rms_right = rms_r_reg;

endmodule

// ===== rtl/sprm_ctrl.sv =====
// sprm_ctrl: controller that sequences accumulation, division, square root and output
// drives the datapath through sprm_cmd_t; depends on sprm_pkg

module sprm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sprm_pkg::sprm_stat_t  stat,
    output logic                  in_ready,
    output sprm_pkg::sprm_cmd_t   cmd
);
    import sprm_pkg::*;

    typedef enum logic [5:0] {
        ST_ACCUM = 6'b000001,
        ST_DRAIN = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_SQRT  = 6'b001000,
        ST_STORE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               chan_reg, chan_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_ACCUM: begin
                in_ready = 1'b1;
                if (stat.in_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (stat.snap_done) begin
                    cmd.div_load = 1'b1;
                    cmd.chan     = 1'b0;
                    chan_next    = 1'b0;
                    step_next    = STEP_W'(DIV_STEPS - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0) begin
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store_rms = 1'b1;
                if (chan_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    // right channel reuses the same unit
                    cmd.div_load = 1'b1;
                    cmd.chan     = 1'b1;
                    chan_next    = 1'b1;
                    step_next    = STEP_W'(DIV_STEPS - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
            chan_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

// ===== rtl/stereo_peak_rms_meter.sv =====
// Stereo block peak and RMS meter. Frames stream in at one word per clock while a block is
// open; the word flagged by s_tlast closes the block, after which s_tready stays low while
// the totals are captured, then per channel through the divider steps, the square root steps
// and a store, and then while the output register is loaded, because a single bit-serial
// divider and square root unit serves both channels in turn. The result word sits in an
// output register, so the next block can start while it waits for m_tready; a block that
// finishes before that word leaves keeps s_tready low until the output register frees up.
// Peaks are magnitudes in Q1.23 scale, rms is floor(sqrt(floor(sum/count))) over at most
// the first 4096 frames of a block, and mono_mode (cfg_wdata) copies the left sample to
// both channels.
// depends on sprm_pkg, sprm_accum, sprm_arith, sprm_ctrl

module stereo_peak_rms_meter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,   // mono_mode
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sprm_pkg::S_DATA_W-1:0]     s_tdata,     // sample_left, sample_right
    input  logic                              s_tlast,     // block_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // peak_left, peak_right, rms_left, rms_right, frames_in_block, zero fill
    output logic [sprm_pkg::M_DATA_W-1:0]     m_tdata
);
    import sprm_pkg::*;

    logic        mono_reg;
    logic        accept;
    sprm_cmd_t   cmd;
    sprm_stat_t  stat;
    logic        snap_done;

    logic [MAG_W-1:0]  peak_l, peak_r;
    logic [SUM_W-1:0]  sum_l, sum_r;
    logic [CNT_W-1:0]  frames;
    logic [ROOT_W-1:0] rms_l, rms_r;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mono_reg <= 1'b0;
        end else if (cfg_we) begin
            mono_reg <= cfg_wdata;
        end
    end

    assign stat.in_last   = s_tvalid && s_tlast;
    assign stat.snap_done = snap_done;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    sprm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    sprm_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .mono_mode    (mono_reg),
        .sample_left  (s_tdata[SAMPLE_BITS-1:0]),
        .sample_right (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .block_end    (s_tlast),
        .snap_done    (snap_done),
        .peak_left    (peak_l),
        .peak_right   (peak_r),
        .sum_left     (sum_l),
        .sum_right    (sum_r),
        .frames       (frames)
    );

    sprm_arith u_arith (
        .aclk      (aclk),
        .cmd       (cmd),
        .sum_left  (sum_l),
        .sum_right (sum_r),
        .frames    (frames),
        .rms_left  (rms_l),
        .rms_right (rms_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {{(M_DATA_W - 4*MAG_W - CNT_W){1'b0}},
                            frames, rms_r, rms_l, peak_r, peak_l};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sv/tb_stereo_peak_rms_meter.sv =====
// tb_stereo_peak_rms_meter: self-checking bench for the stereo block peak and rms meter
// drives frame words with bursts and gaps, stalls the result side, predicts levels in-bench
// depends on sprm_pkg and stereo_peak_rms_meter
`timescale 1ns / 1ps

module tb_stereo_peak_rms_meter;

    localparam int SB         = sprm_pkg::SAMPLE_BITS;
    localparam int MAXF       = sprm_pkg::MAX_FRAMES;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [SB-1:0] peak_l;
        logic [SB-1:0] peak_r;
        logic [SB-1:0] rms_l;
        logic [SB-1:0] rms_r;
        logic [12:0]   frames;
    } level_t;

    typedef struct packed {
        bit                   mono;
        logic signed [SB-1:0] l;
        logic signed [SB-1:0] r;
        bit                   last;
        bit                   given;
        level_t               levels;
    } frame_row_t;

    localparam level_t NO_LEVELS = '0;
    localparam int N_ROWS = 18;

    // directed frames; typed levels only where they follow at a glance
    frame_row_t script [0:N_ROWS-1] = '{
        '{1'b0, 24'sd0, 24'sd0, 1'b1, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd0, 13'd1}},
        '{1'b0, -24'sd8388608, 24'sd8388607, 1'b1, 1'b1,
          '{24'd8388608, 24'd8388607, 24'd8388608, 24'd8388607, 13'd1}},
        '{1'b0, 24'sd8388607, -24'sd8388608, 1'b1, 1'b1,
          '{24'd8388607, 24'd8388608, 24'd8388607, 24'd8388608, 13'd1}},
        '{1'b0, 24'sd1, -24'sd1, 1'b1, 1'b1, '{24'd1, 24'd1, 24'd1, 24'd1, 13'd1}},
        '{1'b0, -24'sd1, 24'sd2, 1'b0, 1'b0, NO_LEVELS},
        '{1'b0, 24'sd3, -24'sd4, 1'b0, 1'b0, NO_LEVELS},
        '{1'b0, -24'sd8388608, 24'sd100, 1'b0, 1'b0, NO_LEVELS},
        '{1'b0, 24'sd8388607, -24'sd8388607, 1'b1, 1'b0, NO_LEVELS},
        '{1'b0, 24'sd5592405, -24'sd5592406, 1'b0, 1'b0, NO_LEVELS},
        '{1'b0, -24'sd5592406, 24'sd5592405, 1'b1, 1'b0, NO_LEVELS},
        '{1'b1, -24'sd8388608, 24'sd1234, 1'b1, 1'b1,
          '{24'd8388608, 24'd8388608, 24'd8388608, 24'd8388608, 13'd1}},
        '{1'b1, 24'sd8388607, -24'sd8388608, 1'b1, 1'b1,
          '{24'd8388607, 24'd8388607, 24'd8388607, 24'd8388607, 13'd1}},
        '{1'b1, 24'sd500, -24'sd8388608, 1'b0, 1'b0, NO_LEVELS},
        '{1'b1, -24'sd700, 24'sd3, 1'b0, 1'b0, NO_LEVELS},
        '{1'b1, -24'sd1, 24'sd0, 1'b1, 1'b0, NO_LEVELS},
        '{1'b1, 24'sd0, 24'sd8388607, 1'b1, 1'b1, '{24'd0, 24'd0, 24'd0, 24'd0, 13'd1}},
        '{1'b1, 24'sd12345, -24'sd54321, 1'b0, 1'b0, NO_LEVELS},
        '{1'b1, -24'sd8388608, 24'sd77, 1'b1, 1'b0, NO_LEVELS}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic                          cfg_wdata = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sprm_pkg::S_DATA_W-1:0] s_tdata = '0;   // sample_left, sample_right
    logic                          s_tlast = 1'b0; // block_end
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // peak_left, peak_right, rms_left, rms_right, frames_in_block, zero fill
    logic [sprm_pkg::M_DATA_W-1:0] m_tdata;

    stereo_peak_rms_meter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // level meter state as the bench sees it
    bit                mono_now;
    logic [SB-1:0]     peak_l = '0;
    logic [SB-1:0]     peak_r = '0;
    longint unsigned   sum_l, sum_r;
    int                frames_seen;

    level_t            pending_levels[$];
    int                errors;
    int                frames_sent;
    int                burst_left;
    int                idle_cycles;
    int                stall_left;
    int unsigned       cycle_no;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [SB-1:0] abs_q23(input logic signed [SB-1:0] x);
        logic [SB:0] wide;
        wide = {x[SB-1], x};
        return x[SB-1] ? SB'(-wide) : SB'(wide);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // fold one frame into the block totals; returns 1 when the block closes
    function automatic bit fold_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                                      input bit last, output level_t lv);
        logic [SB-1:0] ml, mr;
        ml = abs_q23(l);
        mr = mono_now ? ml : abs_q23(r);
        lv = '0;
        if (ml > peak_l)
            peak_l = ml;
        if (mr > peak_r)
            peak_r = mr;
        // past the frame limit only the peaks move
        if (frames_seen < MAXF) begin
            sum_l += 64'(ml) * 64'(ml);
            sum_r += 64'(mr) * 64'(mr);
            frames_seen++;
        end
        if (!last)
            return 1'b0;
        lv.peak_l = peak_l;
        lv.peak_r = peak_r;
        lv.rms_l  = SB'(floor_root(sum_l / longint'(frames_seen)));
        lv.rms_r  = SB'(floor_root(sum_r / longint'(frames_seen)));
        lv.frames = 13'(frames_seen);
        peak_l = '0;
        peak_r = '0;
        sum_l = 0;
        sum_r = 0;
        frames_seen = 0;
        return 1'b1;
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        unique case ($urandom_range(0, 9))
            0: return -24'sd8388608;
            1: return 24'sd8388607;
            2: return 24'sd0;
            3, 4: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
            default: return raw[SB-1:0];
        endcase
    endfunction

    task automatic send_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                              input bit last, input bit given, input level_t typed);
        level_t lv;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        frames_sent++;
        if (fold_frame(l, r, last, lv))
            pending_levels = {pending_levels, (given ? typed : lv)};
    endtask

    // mode change only with every block closed and every level word collected
    task automatic set_mono(input bit m);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mono_now = m;
    endtask

    task automatic send_block(input int len);
        logic signed [SB-1:0] l, r;
        for (int k = 0; k < len; k++) begin
            l = pick_sample();
            r = pick_sample();
            send_frame(l, r, k == len - 1, 1'b0, NO_LEVELS);
        end
    endtask

    task automatic run_phase(input bit m, input int n_frames);
        int start;
        set_mono(m);
        start = frames_sent;
        while (frames_sent - start < n_frames)
            send_block(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 40));
    endtask

    function automatic void cmp_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    // result side: stall pattern plus checking
    always @(posedge aclk) begin
        level_t want, got;
        cycle_no <= cycle_no + 1;
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!cycle_no[10] && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 19);
        end else begin
            m_tready <= 1'b1;
        end
        if (m_tvalid && m_tready) begin
            got.peak_l = m_tdata[SB-1:0];
            got.peak_r = m_tdata[2*SB-1:SB];
            got.rms_l  = m_tdata[3*SB-1:2*SB];
            got.rms_r  = m_tdata[4*SB-1:3*SB];
            got.frames = m_tdata[4*SB+12:4*SB];
            if (pending_levels.size() == 0) begin
                $error("level word with nothing expected");
                errors++;
            end else begin
                want = pending_levels.pop_front();
                cmp_field("peak_left", want.peak_l, got.peak_l);
                cmp_field("peak_right", want.peak_r, got.peak_r);
                cmp_field("rms_left", want.rms_l, got.rms_l);
                cmp_field("rms_right", want.rms_r, got.rms_r);
                cmp_field("frames_in_block", want.frames, got.frames);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("tb_stereo_peak_rms_meter NOT OK");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        set_mono(1'b0);

        for (int i = 0; i < N_ROWS; i++) begin
            if (script[i].mono != mono_now)
                set_mono(script[i].mono);
            send_frame(script[i].l, script[i].r, script[i].last, script[i].given,
                       script[i].levels);
        end

        run_phase(1'b1, 270);
        run_phase(1'b0, 270);
        run_phase(1'b1, 270);

        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("tb_stereo_peak_rms_meter OK");
        else
            $display("tb_stereo_peak_rms_meter NOT OK");
        $finish;
    end

endmodule

// ===== stereo_peak_rms_meter.f =====
rtl/sprm_pkg.sv
rtl/sprm_accum.sv
rtl/sprm_arith.sv
rtl/sprm_ctrl.sv
rtl/stereo_peak_rms_meter.sv
tb/sv/tb_stereo_peak_rms_meter.sv
